FILE: sv/dtrq_pkg.sv
// ----------------------------------------------------------------------------
// dtrq_pkg
// Shared codes and constants for the deduplicating task run queue.
// ----------------------------------------------------------------------------
package dtrq_pkg;

	localparam int unsigned TASK_ID_W = 4;
	localparam int unsigned MAX_RUN   = 16;
	localparam int unsigned RUN_CNT_W = 4;

	// Request codes on the action field.
	localparam logic ACT_POST  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_RUN    = 1'b1;

	// Post outcomes.
	localparam logic ST_QUEUED  = 1'b0;
	localparam logic ST_ALREADY = 1'b1;

endpackage

FILE: sv/dedup_task_run_queue_unit.sv
// ----------------------------------------------------------------------------
// dedup_task_run_queue_unit
// FIFO run queue of task ids in which each task is queued at most once.
// A post gives its status result in the cycle after the request is taken
// and busy never rises for it. A drain of N tasks gives one result per cycle
// after the request, busy high until the last one; the walk is bound by the
// registered read of the link memory. An empty drain gives none.
// The receiver cannot stall. Reset empties the queue; link memory is not reset.
// ----------------------------------------------------------------------------
module dedup_task_run_queue_unit #(
	parameter int unsigned NUM_TASKS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [dtrq_pkg::TASK_ID_W-1:0] task_id,
	output logic                           strobe,
	output logic                           kind,
	output logic                           status,
	output logic [dtrq_pkg::TASK_ID_W-1:0] run_task_id,
	output logic                           last_of_run,
	output logic                           pending_raised,
	output logic                           queue_nonempty
);

	localparam int unsigned IDX_W = $clog2(NUM_TASKS);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t                          state_q;
	logic [NUM_TASKS-1:0]            flags_q;
	logic [IDX_W-1:0]                head_q;
	logic [IDX_W-1:0]                tail_q;
	logic                            empty_q;
	logic [IDX_W-1:0]                cur_q;
	logic                            first_q;
	logic [dtrq_pkg::RUN_CNT_W-1:0]  cnt_q;

	logic                            accept;
	logic [IDX_W-1:0]                id_idx;
	logic                            id_ok;
	logic                            refused;
	logic                            link_we;
	logic [IDX_W-1:0]                rd_addr;
	logic [IDX_W-1:0]                rd_data;
	logic [IDX_W-1:0]                cur;
	logic                            walk_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign id_idx = IDX_W'(task_id);
	assign id_ok  = (32'(task_id) < NUM_TASKS);
	assign refused = !id_ok || flags_q[id_idx];

	// A new tail is linked behind the old one only when the queue already holds tasks.
	assign link_we = accept && (action == dtrq_pkg::ACT_POST) && !refused && !empty_q;

	// The first step of a walk uses the head; later steps follow the link just read.
	assign cur       = first_q ? cur_q : rd_data;
	assign rd_addr   = (state_q == S_WALK) ? cur : head_q;
	assign walk_last = (cur == tail_q) ||
		(cnt_q == dtrq_pkg::RUN_CNT_W'(dtrq_pkg::MAX_RUN - 1));

	dtrq_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NUM_TASKS)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (link_we),
		.wr_addr(tail_q),
		.wr_data(id_idx),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			flags_q        <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			empty_q        <= 1'b1;
			cur_q          <= '0;
			first_q        <= 1'b0;
			cnt_q          <= '0;
			strobe         <= 1'b0;
			kind           <= dtrq_pkg::KIND_STATUS;
			status         <= dtrq_pkg::ST_QUEUED;
			run_task_id    <= '0;
			last_of_run    <= 1'b0;
			pending_raised <= 1'b0;
			queue_nonempty <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && action == dtrq_pkg::ACT_POST) begin
						strobe         <= 1'b1;
						kind           <= dtrq_pkg::KIND_STATUS;
						run_task_id    <= '0;
						last_of_run    <= 1'b1;
						if (refused) begin
							status         <= dtrq_pkg::ST_ALREADY;
							pending_raised <= 1'b0;
							queue_nonempty <= !empty_q;
						end else begin
							status          <= dtrq_pkg::ST_QUEUED;
							pending_raised  <= empty_q;
							queue_nonempty  <= 1'b1;
							flags_q[id_idx] <= 1'b1;
							tail_q          <= id_idx;
							empty_q         <= 1'b0;
							if (empty_q) begin
								head_q <= id_idx;
							end
						end
					end else if (accept && !empty_q) begin
						state_q <= S_WALK;
						cur_q   <= head_q;
						first_q <= 1'b1;
						cnt_q   <= '0;
					end
				end
				S_WALK: begin
					strobe         <= 1'b1;
					kind           <= dtrq_pkg::KIND_RUN;
					status         <= dtrq_pkg::ST_QUEUED;
					run_task_id    <= dtrq_pkg::TASK_ID_W'(cur);
					last_of_run    <= walk_last;
					pending_raised <= 1'b0;
					queue_nonempty <= !walk_last;
					first_q        <= 1'b0;
					cnt_q          <= cnt_q + 1'b1;
					if (walk_last) begin
						state_q <= S_IDLE;
						flags_q <= '0;
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/dtrq_ram.sv
// ----------------------------------------------------------------------------
// dtrq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module dtrq_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
